[rtl/vqbd_pkg.sv]
// Shared types and constants for the 4x4 VQ block decoder.
`default_nettype none
package vqbd_pkg;

  localparam int CODEBOOK_ENTRIES = 4096;
  localparam int IDX_W            = $clog2(CODEBOOK_ENTRIES);
  localparam int CODE_IDX_W       = 12;
  localparam int ENTRY_ROWS       = 4;
  localparam int ROW_SEL_W        = 2;
  localparam int ROW_W            = 32;
  localparam int LANES            = 2;
  localparam int STRIP_ROWS       = LANES * ENTRY_ROWS;
  localparam int STRIP_W          = $clog2(STRIP_ROWS);
  localparam int CODE_W           = 24;

  localparam int S_TDATA_W = 72;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 40;

  localparam logic [ROW_W-1:0] BLACK_ROW = '1;

  typedef enum logic {
    FUNC_LOAD   = 1'b0,
    FUNC_DECODE = 1'b1
  } func_t;

  // codebook row write, broadcast to every lane
  typedef struct packed {
    logic                 en;
    logic [IDX_W-1:0]     addr;
    logic [ROW_SEL_W-1:0] row;
    logic [ROW_W-1:0]     data;
  } wr_t;

  // per-strip control that rides with the fetched rows
  typedef struct packed {
    logic             blank;
    logic [LANES-1:0] oor;
  } blk_ctl_t;

  typedef logic [ENTRY_ROWS-1:0][ROW_W-1:0] blk_rows_t;

endpackage
`default_nettype wire

[rtl/vqbd_lane.sv]
// One decode lane: a codebook copy in four row banks, fetches a whole 4x4 block.
`default_nettype none
module vqbd_lane (
  input  wire logic                        clk,
  input  wire vqbd_pkg::wr_t               wr,
  input  wire logic                        rd_en,
  input  wire logic [vqbd_pkg::CODE_IDX_W-1:0] rd_idx,
  output vqbd_pkg::blk_rows_t              rd_rows,
  output logic                             rd_oor
);
  import vqbd_pkg::*;

  logic [IDX_W-1:0] rd_addr;
  logic             idx_oor;

  assign rd_addr = rd_idx[IDX_W-1:0];
  assign idx_oor = {1'b0, rd_idx} >= (CODE_IDX_W + 1)'(CODEBOOK_ENTRIES);

  for (genvar r = 0; r < ENTRY_ROWS; r++) begin : g_bank
    logic [ROW_W-1:0] bank [CODEBOOK_ENTRIES];
    logic [ROW_W-1:0] bank_q;

    always_ff @(posedge clk) begin
      if (wr.en && wr.row == ROW_SEL_W'(r)) begin
        bank[wr.addr] <= wr.data;
      end
      if (rd_en) begin
        bank_q <= bank[rd_addr];
      end
    end

    assign rd_rows[r] = bank_q;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_oor <= idx_oor;
    end
  end

endmodule
`default_nettype wire

[rtl/vqbd_merge.sv]
// Merge stage: holds both lanes' blocks and streams the 8-row strip.
`default_nettype none
module vqbd_merge (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire vqbd_pkg::blk_rows_t           in_rows [vqbd_pkg::LANES],
  input  wire vqbd_pkg::blk_ctl_t            in_ctl,
  output logic                               take,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic [vqbd_pkg::ROW_W-1:0]         pixel_row,
  output logic [vqbd_pkg::STRIP_W-1:0]       row_offset,
  output logic                               last
);
  import vqbd_pkg::*;

  logic [ROW_W-1:0]   strip [STRIP_ROWS];
  logic               busy;
  logic [STRIP_W-1:0] cnt;
  logic               cnt_end;

  assign cnt_end = cnt == STRIP_W'(STRIP_ROWS - 1);
  assign take    = in_valid && (!busy || (out_ready && cnt_end));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (take) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy && out_ready) begin
      if (cnt_end) begin
        busy <= 1'b0;
      end
      cnt <= cnt + 1'b1;
    end
  end

  // blank and out-of-range are folded in as the strip is loaded
  for (genvar k = 0; k < STRIP_ROWS; k++) begin : g_row
    always_ff @(posedge clk) begin
      if (take) begin
        if (in_ctl.blank) begin
          strip[k] <= BLACK_ROW;
        end else if (in_ctl.oor[k / ENTRY_ROWS]) begin
          strip[k] <= '0;
        end else begin
          strip[k] <= in_rows[k / ENTRY_ROWS][k % ENTRY_ROWS];
        end
      end
    end
  end

  assign out_valid  = busy;
  assign pixel_row  = strip[cnt];
  assign row_offset = cnt;
  assign last       = cnt_end;

endmodule
`default_nettype wire

[rtl/vq_block_decoder_4x4_core.sv]
// Top level of the 4x4 VQ block decoder: input decode, lanes and merge stage.
//
// Usage:
//   s_* channel takes one word per item. s_tuser[0] = func (0 load, 1 decode),
//   s_tuser[1] = blank. A load word writes one 4-pixel row of a codebook
//   entry into both lanes' codebook copies and produces nothing. A decode
//   word carries two 12-bit indices; lane 0 fetches the block of the first
//   index, lane 1 the second, all four rows of each in one memory read.
//   m_* channel returns eight words per decode, rows 0-3 from the first
//   index and 4-7 from the second; m_tlast marks the eighth row.
// Path: decode word -> fetch register -> merge strip -> m_* channel.
// Throughput: the merge stage puts out one output row per cycle while
//   m_tready is high; a decode is fetched while the previous strip
//   still drains, so the output runs with no gaps. Loads go one per cycle
//   unless the fetch register holds a strip not yet taken by the merge stage.
// Reset: clears only the pipeline valids and row counter; codebook content
//   is undefined until written.
// Stall: with m_tready low the current row holds; one more decode can be
//   fetched and waits, after which s_tready drops.
`default_nettype none
module vq_block_decoder_4x4_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // code_bytes[23:0], entry_index[35:24], entry_row[37:36], entry_data[69:38]
  input  wire logic [vqbd_pkg::S_TDATA_W-1:0] s_tdata,
  // func[0], blank[1]
  input  wire logic [vqbd_pkg::S_TUSER_W-1:0] s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // pixel_row[31:0], row_offset[34:32]
  output logic [vqbd_pkg::M_TDATA_W-1:0]      m_tdata,
  output logic                                m_tlast
);
  import vqbd_pkg::*;

  // input word fields
  func_t                 func;
  logic                  blank;
  logic [CODE_W-1:0]     code_bytes;
  logic [CODE_IDX_W-1:0] entry_index;
  logic [ROW_SEL_W-1:0]  entry_row;
  logic [ROW_W-1:0]      entry_data;

  assign func        = func_t'(s_tuser[0]);
  assign blank       = s_tuser[1];
  assign code_bytes  = s_tdata[23:0];
  assign entry_index = s_tdata[35:24];
  assign entry_row   = s_tdata[37:36];
  assign entry_data  = s_tdata[69:38];

  logic       acc;
  logic       take;
  logic       fetch_valid;
  logic       fetch_blank;
  wr_t        wr;
  blk_rows_t  lane_rows [LANES];
  logic [LANES-1:0]          lane_oor;
  logic [CODE_IDX_W-1:0]     lane_idx [LANES];
  blk_ctl_t   fetch_ctl;

  // fetch register frees up in the same cycle the merge stage takes it
  assign s_tready = !fetch_valid || take;
  assign acc      = s_tvalid && s_tready;

  // loads beyond the codebook size are dropped
  assign wr.en   = acc && func == FUNC_LOAD
                   && {1'b0, entry_index} < (CODE_IDX_W + 1)'(CODEBOOK_ENTRIES);
  assign wr.addr = entry_index[IDX_W-1:0];
  assign wr.row  = entry_row;
  assign wr.data = entry_data;

  // first index sits in the high 12 bits
  assign lane_idx[0] = code_bytes[2*CODE_IDX_W-1:CODE_IDX_W];
  assign lane_idx[1] = code_bytes[CODE_IDX_W-1:0];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    vqbd_lane u_lane (
      .clk     (clk),
      .wr      (wr),
      .rd_en   (acc && func == FUNC_DECODE),
      .rd_idx  (lane_idx[l]),
      .rd_rows (lane_rows[l]),
      .rd_oor  (lane_oor[l])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fetch_valid <= 1'b0;
    end else if (acc && func == FUNC_DECODE) begin
      fetch_valid <= 1'b1;
    end else if (take) begin
      fetch_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && func == FUNC_DECODE) begin
      fetch_blank <= blank;
    end
  end

  assign fetch_ctl.blank = fetch_blank;
  assign fetch_ctl.oor   = lane_oor;

  logic [ROW_W-1:0]   pixel_row;
  logic [STRIP_W-1:0] row_offset;

  vqbd_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (fetch_valid),
    .in_rows    (lane_rows),
    .in_ctl     (fetch_ctl),
    .take       (take),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .pixel_row  (pixel_row),
    .row_offset (row_offset),
    .last       (m_tlast)
  );

  assign m_tdata = {{(M_TDATA_W - ROW_W - STRIP_W){1'b0}}, row_offset, pixel_row};

`ifndef SYNTHESIS
  // merge stage only loads a fetched strip
  a_take_needs_fetch: assert property (@(posedge clk) disable iff (rst)
    take |-> fetch_valid)
    else $error("merge took an empty fetch register");

  // a strip is never replaced before its eighth row leaves
  a_no_early_take: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !(m_tready && m_tlast)) |-> !take)
    else $error("strip overwritten mid-output");

  // rows of a strip come out in order
  a_row_order: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=>
      (m_tvalid && row_offset == $past(row_offset) + 1'b1))
    else $error("row offset out of sequence");

  // output goes idle after the last row if nothing was waiting
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast && !take) |=> !m_tvalid)
    else $error("output valid after strip end with nothing fetched");
`endif

endmodule
`default_nettype wire

[dv/vq_block_decoder_4x4_checker.sv]
`timescale 1ns / 100ps
// Checker for the 4x4 VQ block decoder: keeps a codebook copy, predicts strips, compares rows.
module vq_block_decoder_4x4_checker (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  input  wire logic                           s_tready,
  input  wire logic [vqbd_pkg::S_TDATA_W-1:0] s_tdata,
  input  wire logic [vqbd_pkg::S_TUSER_W-1:0] s_tuser,
  input  wire logic                           m_tvalid,
  input  wire logic                           m_tready,
  input  wire logic [vqbd_pkg::M_TDATA_W-1:0] m_tdata,
  input  wire logic                           m_tlast,
  output int                                  errors,
  output int                                  rows_pending
);
  import vqbd_pkg::*;

  // input word as packed on s_tdata, lowest field last
  typedef struct packed {
    logic [1:0]            pad;
    logic [ROW_W-1:0]      data;
    logic [ROW_SEL_W-1:0]  row;
    logic [CODE_IDX_W-1:0] index;
    logic [CODE_W-1:0]     code;
  } in_word_t;

  typedef struct {
    logic [ROW_W-1:0]   pixels;
    logic [STRIP_W-1:0] offset;
    logic               last;
  } strip_row_t;

  logic [ROW_W-1:0] book [CODEBOOK_ENTRIES*ENTRY_ROWS];
  strip_row_t       rows_due [$];

  function automatic logic [ROW_W-1:0] book_row(input logic [CODE_IDX_W-1:0] idx,
                                                input logic [ROW_SEL_W-1:0] row);
    if (int'(idx) >= CODEBOOK_ENTRIES) return '0;
    return book[{idx[IDX_W-1:0], row}];
  endfunction

  // two indices -> eight rows; first index fills rows 0-3
  task automatic expand_strip(input logic [CODE_W-1:0] code, input logic blank);
    logic [CODE_IDX_W-1:0] lane_idx [LANES];
    strip_row_t            r;
    lane_idx[0] = code[CODE_W-1 -: CODE_IDX_W];
    lane_idx[1] = code[CODE_IDX_W-1:0];
    for (int k = 0; k < STRIP_ROWS; k++) begin
      r.pixels = blank ? BLACK_ROW
                       : book_row(lane_idx[k / ENTRY_ROWS], ROW_SEL_W'(k % ENTRY_ROWS));
      r.offset = STRIP_W'(k);
      r.last   = (k == STRIP_ROWS - 1);
      rows_due.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    in_word_t   word;
    strip_row_t want;
    if (rst) begin
      rows_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (rows_due.size() == 0) begin
          errors++;
          $error("unexpected output word: pixel_row %h row_offset %0d last %0b",
                 m_tdata[ROW_W-1:0], m_tdata[ROW_W +: STRIP_W], m_tlast);
        end else begin
          want = rows_due.pop_front();
          if (m_tdata[ROW_W-1:0] !== want.pixels) begin
            errors++;
            $error("pixel_row mismatch: expected %h, actual %h",
                   want.pixels, m_tdata[ROW_W-1:0]);
          end
          if (m_tdata[ROW_W +: STRIP_W] !== want.offset) begin
            errors++;
            $error("row_offset mismatch: expected %0d, actual %0d",
                   want.offset, m_tdata[ROW_W +: STRIP_W]);
          end
          if (m_tlast !== want.last) begin
            errors++;
            $error("last mismatch: expected %0b, actual %0b", want.last, m_tlast);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        word = s_tdata;
        if (func_t'(s_tuser[0]) == FUNC_LOAD) begin
          if (int'(word.index) < CODEBOOK_ENTRIES)
            book[{word.index[IDX_W-1:0], word.row}] = word.data;
        end else begin
          expand_strip(word.code, s_tuser[1]);
        end
      end
    end
    rows_pending <= rows_due.size();
  end

endmodule

[dv/tb_vq_block_decoder_4x4_core.sv]
`timescale 1ns / 100ps
// Testbench top for the 4x4 VQ block decoder: stimulus, output stalls and verdict.
module tb_vq_block_decoder_4x4_core;
  import vqbd_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS = 180;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  // code_bytes[23:0], entry_index[35:24], entry_row[37:36], entry_data[69:38]
  logic [S_TDATA_W-1:0] s_tdata  = '0;
  // func[0], blank[1]
  logic [S_TUSER_W-1:0] s_tuser  = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  // pixel_row[31:0], row_offset[34:32]
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tlast;

  int mismatches;
  int rows_pending;
  int cycles    = 0;
  int sink_wait = 0;
  bit quiet     = 1'b0;  // set: neither side idles

  // which rows of each entry hold data; only fully written entries get decoded
  bit [ENTRY_ROWS-1:0]   rows_set [CODEBOOK_ENTRIES];
  logic [IDX_W-1:0]      full_entries [$];

  vq_block_decoder_4x4_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  vq_block_decoder_4x4_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast),
    .errors       (mismatches),
    .rows_pending (rows_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[vq_block_decoder_4x4_core] ERROR");
      $finish;
    end
  end

  // output side: after each taken word, drop ready for a randomly drawn wait, unless quiet
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      sink_wait = 0;
    end else if (m_tready && m_tvalid) begin
      sink_wait = quiet ? 0 : $urandom_range(0, 14);
      m_tready <= (sink_wait == 0);
    end else if (!m_tready) begin
      if (sink_wait > 0) sink_wait--;
      m_tready <= (sink_wait == 0);
    end
  end

  // One word on the input side. Valid is only lowered when a gap is drawn, so
  // back-to-back words never see a low and a high in the same step.
  task automatic send_word(input func_t func, input logic [CODE_W-1:0] code,
                           input logic blank, input logic [CODE_IDX_W-1:0] idx,
                           input logic [ROW_SEL_W-1:0] row, input logic [ROW_W-1:0] data);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_TDATA_W-70){1'b0}}, data, row, idx, code};
    s_tuser  <= {blank, func};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // codebook row write; code and blank are don't-care, so randomize them
  task automatic load_row(input logic [IDX_W-1:0] idx, input logic [ROW_SEL_W-1:0] row,
                          input logic [ROW_W-1:0] data);
    send_word(FUNC_LOAD, CODE_W'($urandom), 1'($urandom), CODE_IDX_W'(idx), row, data);
    if (rows_set[idx] != '1) begin
      rows_set[idx][row] = 1'b1;
      if (rows_set[idx] == '1) full_entries.push_back(idx);
    end
  endtask

  // decode; entry fields are don't-care
  task automatic decode(input logic [IDX_W-1:0] first, input logic [IDX_W-1:0] second,
                        input logic blank);
    send_word(FUNC_DECODE, {CODE_IDX_W'(first), CODE_IDX_W'(second)}, blank,
              CODE_IDX_W'($urandom), ROW_SEL_W'($urandom), $urandom);
  endtask

  // park the input side until every expected row has come out
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (rows_pending != 0) @(posedge clk);
  endtask

  function automatic logic [IDX_W-1:0] pick_entry();
    return full_entries[$urandom_range(0, full_entries.size() - 1)];
  endfunction

  initial begin
    int               items;
    int               kind;
    bit               paused;
    logic [IDX_W-1:0] fresh;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // --- directed: extreme indices, extreme pixel values, blank, same index twice
    load_row(12'h000, 2'd0, 32'h0000_0000);
    load_row(12'h000, 2'd1, 32'hFFFF_FFFF);
    load_row(12'h000, 2'd2, 32'h8040_2010);
    load_row(12'h000, 2'd3, 32'h0102_0304);
    load_row(12'hFFF, 2'd3, 32'hFFFF_FFFF);
    load_row(12'hFFF, 2'd2, 32'h0000_0000);
    load_row(12'hFFF, 2'd1, 32'h7F3F_C0FE);
    load_row(12'hFFF, 2'd0, 32'hFE01_FC03);
    load_row(12'hAAA, 2'd0, 32'hAAAA_AAAA);
    load_row(12'hAAA, 2'd1, 32'h5555_5555);
    load_row(12'hAAA, 2'd2, $urandom);
    load_row(12'hAAA, 2'd3, $urandom);
    load_row(12'h555, 2'd0, $urandom);
    load_row(12'h555, 2'd1, $urandom);
    load_row(12'h555, 2'd2, $urandom);
    load_row(12'h555, 2'd3, $urandom);
    decode(12'h000, 12'hFFF, 1'b0);
    decode(12'hFFF, 12'h000, 1'b0);
    decode(12'hAAA, 12'h555, 1'b0);
    decode(12'h555, 12'h555, 1'b0);
    decode(12'hFFF, 12'hFFF, 1'b1);
    decode(12'hAAA, 12'h000, 1'b1);
    // overwrite one row, then read it back
    load_row(12'hAAA, 2'd2, 32'h1357_9BDF);
    decode(12'hAAA, 12'hAAA, 1'b0);

    // --- random: mostly decodes of written entries, full-entry loads to grow
    // the codebook, single-row writes anywhere
    items  = 0;
    paused = 1'b0;
    while (items < RANDOM_ITEMS) begin
      quiet = (items >= 40 && items < 70) || (items >= 140 && items < 160);
      if (items >= 100 && !paused) begin
        drain();
        paused = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
        fresh = IDX_W'($urandom);
        for (int r = 0; r < ENTRY_ROWS; r++) load_row(fresh, ROW_SEL_W'(r), $urandom);
        items += ENTRY_ROWS;
      end else if (kind < 30) begin
        load_row(IDX_W'($urandom), ROW_SEL_W'($urandom), $urandom);
        items++;
      end else begin
        decode(pick_entry(), pick_entry(), ($urandom_range(0, 6) == 0));
        items++;
      end
    end
    quiet = 1'b0;

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && rows_pending == 0) begin
      $display("[vq_block_decoder_4x4_core] OK");
    end else begin
      $display("[vq_block_decoder_4x4_core] ERROR");
    end
    $finish;
  end

endmodule

[vq_block_decoder_4x4_core.f]
rtl/vqbd_pkg.sv
rtl/vqbd_lane.sv
rtl/vqbd_merge.sv
rtl/vq_block_decoder_4x4_core.sv
dv/vq_block_decoder_4x4_checker.sv
dv/tb_vq_block_decoder_4x4_core.sv
